FILE: rtl/online_bin_covering_macros.svh
// Assertion macros used by the checker file.
`ifndef ONLINE_BIN_COVERING_MACROS_SVH
`define ONLINE_BIN_COVERING_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/obc_pkg.sv
`timescale 1ns / 1ps

package obc_pkg;

	localparam int MAX_CLASSES = 64;
	localparam int BIN_W       = $clog2(MAX_CLASSES);
	localparam int CLS_W       = 7;
	localparam int ITEM_W      = 30;
	localparam int LEVEL_W     = 31;
	localparam int COUNT_W     = 32;
	localparam int CFG_IDX_W   = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLASSES   = 2'd2;

	localparam logic [ITEM_W-1:0] THRESHOLD_RST = ITEM_W'(1000);
	localparam logic [CLS_W-1:0]  CLASSES_RST   = CLS_W'(2);
	localparam logic [CLS_W-1:0]  CLASSES_MIN   = CLS_W'(2);
	localparam logic [CLS_W-1:0]  CLASSES_MAX   = CLS_W'(MAX_CLASSES);

	// Mode codes
	localparam logic MODE_NEXT_FIT = 1'b0;
	localparam logic MODE_HARMONIC = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_READ,
		ST_UPDATE,
		ST_FINISH
	} state_t;

endpackage

FILE: rtl/online_bin_covering.sv
`timescale 1ns / 1ps

// Channel  | handshake                  | payload
// ---------+----------------------------+---------------------------------------------
// input    | in_valid / in_stall        | item_size
// output   | out_valid / out_stall      | item_rejected, bin_chosen, bin_covered,
//          |                            | covered_total
// config   | cfg_write                  | cfg_index, cfg_data
//
// Per item: a rejected item goes from idle straight to finish; next fit steps through
// read, update and finish; harmonic first runs the class search over d = 2 to class_count.
// One shared 31-bit adder with a threshold compare does the class search (one step a
// cycle, building item*d by repeated add) and then the bin level update.
// Bin levels live in a 64-entry memory with registered read; per-entry valid flops
// make a never-written bin read as zero, so there is no clearing pass after reset.
// A finished result sits in the output register; the next item is taken meanwhile.
// The sequencer only holds in its last step while the output register is full and
// stalled.

module online_bin_covering (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [obc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [obc_pkg::ITEM_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [obc_pkg::ITEM_W-1:0]    item_size,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          item_rejected,
	output logic [obc_pkg::BIN_W-1:0]     bin_chosen,
	output logic                          bin_covered,
	output logic [obc_pkg::COUNT_W-1:0]   covered_total
);

	import obc_pkg::*;

	state_t               state_q, state_d;

	// configuration
	logic                 mode_q;
	logic [ITEM_W-1:0]    thr_q;
	logic [CLS_W-1:0]     cls_q;

	// item context
	logic [ITEM_W-1:0]    item_q;
	logic                 rej_q;
	logic                 cov_q;
	logic [BIN_W-1:0]     bin_q;
	logic [LEVEL_W-1:0]   acc_q;
	logic [CLS_W-1:0]     d_q;
	logic [COUNT_W-1:0]   cnt_q;

	// bin level store
	logic [LEVEL_W-1:0]   level_mem [MAX_CLASSES];
	logic [LEVEL_W-1:0]   rd_q;
	logic [MAX_CLASSES-1:0] vld_q;

	// output register
	logic                 out_valid_q;
	logic                 rej_out_q;
	logic [BIN_W-1:0]     bin_out_q;
	logic                 cov_out_q;
	logic [COUNT_W-1:0]   cnt_out_q;

	logic                 in_accept;
	logic                 rej_in;
	logic                 out_load;
	logic [CLS_W-1:0]     k_eff;
	logic [LEVEL_W-1:0]   level;
	logic [LEVEL_W-1:0]   op_a;
	logic [LEVEL_W-1:0]   sum;
	logic                 hit;
	logic                 search_end;
	logic [BIN_W-1:0]     bin_sel;
	logic                 mem_wr;

	// Handshake strobes
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign rej_in    = (item_size == '0) || (item_size > thr_q);
	assign out_load  = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	// Clamp class count to 2..MAX_CLASSES
	always_comb begin
		k_eff = cls_q;
		if (cls_q < CLASSES_MIN) begin
			k_eff = CLASSES_MIN;
		end else if (cls_q > CLASSES_MAX) begin
			k_eff = CLASSES_MAX;
		end
	end

	// Shared adder and threshold compare
	assign level = vld_q[bin_q] ? rd_q : '0;
	assign op_a  = (state_q == ST_SEARCH) ? acc_q : level;
	assign sum   = op_a + LEVEL_W'(item_q);
	assign hit   = (sum >= LEVEL_W'(thr_q));

	// Sequencer: next state and class pick
	always_comb begin
		state_d    = state_q;
		search_end = 1'b0;
		bin_sel    = bin_q;
		mem_wr     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					if (rej_in) begin
						state_d = ST_FINISH;
					end else if (mode_q == MODE_HARMONIC) begin
						state_d = ST_SEARCH;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					search_end = 1'b1;
					bin_sel    = BIN_W'(d_q - CLS_W'(2));
					state_d    = ST_READ;
				end else if (d_q == k_eff) begin
					search_end = 1'b1;
					bin_sel    = BIN_W'(k_eff - CLS_W'(1));
					state_d    = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				mem_wr  = 1'b1;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NEXT_FIT;
			thr_q  <= THRESHOLD_RST;
			cls_q  <= CLASSES_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MODE:      mode_q <= cfg_data[0];
				REG_THRESHOLD: thr_q  <= cfg_data;
				REG_CLASSES:   cls_q  <= cfg_data[CLS_W-1:0];
				default: ;
			endcase
		end
	end

	// Item context and search accumulator
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_q <= item_size;
			rej_q  <= rej_in;
			cov_q  <= 1'b0;
			bin_q  <= '0;
			acc_q  <= LEVEL_W'(item_size);
			d_q    <= CLS_W'(2);
		end else if (state_q == ST_SEARCH) begin
			acc_q <= sum;
			d_q   <= d_q + CLS_W'(1);
			if (search_end) begin
				bin_q <= bin_sel;
			end
		end else if (state_q == ST_UPDATE) begin
			cov_q <= hit;
		end
	end

	// Covered count, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_UPDATE && hit && cnt_q != '1) begin
			cnt_q <= cnt_q + COUNT_W'(1);
		end
	end

	// Level memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_wr) begin
			level_mem[bin_q] <= hit ? '0 : sum;
		end
		if (state_q == ST_READ) begin
			rd_q <= level_mem[bin_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (mem_wr) begin
			vld_q[bin_q] <= 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rej_out_q <= rej_q;
			bin_out_q <= rej_q ? '0 : bin_q;
			cov_out_q <= cov_q && !rej_q;
			cnt_out_q <= cnt_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign item_rejected = rej_out_q;
	assign bin_chosen    = bin_out_q;
	assign bin_covered   = cov_out_q;
	assign covered_total = cnt_out_q;

endmodule

FILE: rtl/obc_check.sv
`timescale 1ns / 1ps

`include "online_bin_covering_macros.svh"

module obc_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          item_rejected,
	input logic [obc_pkg::BIN_W-1:0]     bin_chosen,
	input logic                          bin_covered,
	input logic [obc_pkg::COUNT_W-1:0]   covered_total
);

	import obc_pkg::*;

	// A stalled result beat holds
	`OBC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(item_rejected) && $stable(bin_chosen) &&
		$stable(bin_covered) && $stable(covered_total),
		"stalled result beat changed")

	// A rejected item touches no bin
	`OBC_ASSERT_IMP(a_reject_clean, clk, arst_n, out_valid && item_rejected,
		bin_chosen == '0 && !bin_covered, "rejected beat names a bin")

	// The block is busy right after taking an item
	`OBC_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall,
		in_stall, "input taken again without a busy cycle")

	// A covered bin implies a nonzero running count
	`OBC_ASSERT_IMP(a_cover_counts, clk, arst_n, out_valid && bin_covered,
		covered_total != '0, "covered bin with zero total")

endmodule

bind online_bin_covering obc_check u_obc_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.item_rejected (item_rejected),
	.bin_chosen    (bin_chosen),
	.bin_covered   (bin_covered),
	.covered_total (covered_total)
);

FILE: verif/tb_online_bin_covering.sv
`timescale 1ns / 1ps

module tb_online_bin_covering;
	import obc_pkg::*;

	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int DRAIN_CYCLES = 80;
	localparam int HOLD_CYCLES  = 300;
	localparam int MAX_REPORTS  = 10;
	localparam int PHASE_ITEMS  = 100;
	localparam int PHASES       = 16;

	localparam logic [ITEM_W-1:0]    ITEM_MAX   = '1;
	// Index with no register behind it; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic                 rejected;
		logic [BIN_W-1:0]     bin;
		logic                 covered;
		logic [COUNT_W-1:0]   total;
	} placement_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MODE;
	logic [ITEM_W-1:0]    cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [ITEM_W-1:0]    item_size = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 item_rejected;
	logic [BIN_W-1:0]     bin_chosen;
	logic                 bin_covered;
	logic [COUNT_W-1:0]   covered_total;

	online_bin_covering DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.item_size     (item_size),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.item_rejected (item_rejected),
		.bin_chosen    (bin_chosen),
		.bin_covered   (bin_covered),
		.covered_total (covered_total)
	);

	// Shadow copy of the configuration and of the bins
	logic               mode_q      = MODE_NEXT_FIT;
	logic [ITEM_W-1:0]  threshold_q = THRESHOLD_RST;
	logic [CLS_W-1:0]   classes_q   = CLASSES_RST;
	logic [LEVEL_W-1:0] bin_fill [MAX_CLASSES];
	logic [COUNT_W-1:0] cover_tally = '0;

	logic [ITEM_W-1:0] item_q[$];       // sizes waiting to be offered
	placement_t        placement_q[$];  // predicted placements, oldest first

	int   send_idle_pct = 0;
	int   stall_pct     = 0;
	int   mismatches    = 0;
	int   cycle_cnt     = 0;
	logic hold_req      = 1'b0;
	logic hold_ack      = 1'b0;
	int   hold_cnt      = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Place one item into the shadow bins and return the placement it causes
	task automatic place_item(input logic [ITEM_W-1:0] item, output placement_t res);
		int          k;
		int unsigned bin;
		logic [32:0] fill;
		logic [63:0] span;
		res          = '0;
		res.total    = cover_tally;
		if (item == '0 || item > threshold_q) begin
			res.rejected = 1'b1;
			return;
		end
		k = int'(classes_q);
		if (k < int'(CLASSES_MIN))
			k = int'(CLASSES_MIN);
		if (k > int'(CLASSES_MAX))
			k = int'(CLASSES_MAX);
		bin = 0;
		if (mode_q == MODE_HARMONIC) begin
			// smallest class d with item*d reaching the threshold, else the last bin
			bin = k - 1;
			for (int d = 2; d <= k; d++) begin
				span = 64'(item) * 64'(d);
				if (span >= 64'(threshold_q)) begin
					bin = d - 2;
					break;
				end
			end
		end
		fill = 33'(bin_fill[bin]) + 33'(item);
		if (fill >= 33'(threshold_q)) begin
			res.covered   = 1'b1;
			bin_fill[bin] = '0;
			if (cover_tally != '1)
				cover_tally = cover_tally + 1'b1;
		end else begin
			bin_fill[bin] = fill[LEVEL_W-1:0];
		end
		res.bin   = BIN_W'(bin);
		res.total = cover_tally;
	endtask

	task automatic log_fault(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t ns: %s", $time, what);
	endtask

	// Register write; the shadow copy is updated when the write is driven, before the DUT takes it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ITEM_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			REG_MODE:      mode_q      = value[0];
			REG_THRESHOLD: threshold_q = value;
			REG_CLASSES:   classes_q   = value[CLS_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Wait until every offered item is placed and every placement has come out
	task automatic drain();
		do
			@(posedge clk);
		while (item_q.size() != 0 || in_valid || placement_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Random item size, biased toward class boundaries and the edges of the range
	function automatic logic [ITEM_W-1:0] pick_size();
		int unsigned t;
		int unsigned d;
		int unsigned c;
		int unsigned pick;
		t    = 32'(threshold_q);
		pick = $urandom_range(0, 99);
		if (t == 0)
			return ITEM_W'($urandom);
		if (pick < 4)
			return '0;
		if (pick < 9)
			return (t == ITEM_MAX) ? ITEM_MAX : ITEM_W'($urandom_range(t + 1, ITEM_MAX));
		if (pick < 14)
			return ITEM_W'(t);
		if (pick < 18)
			return ITEM_W'(1);
		if (pick < 55) begin
			d = $urandom_range(2, MAX_CLASSES);
			c = (t + d - 1) / d + $urandom_range(0, 2) - 1;
			if (c == 0)
				c = 1;
			if (c > t)
				c = t;
			return ITEM_W'(c);
		end
		return ITEM_W'($urandom_range(1, t));
	endfunction

	// Input driver: one beat per accepted size, with random gaps
	always @(posedge clk) begin : drive
		placement_t res;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				place_item(item_size, res);
				placement_q.push_back(res);
			end
			if (!in_valid || !in_stall) begin
				if (item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid  <= 1'b1;
					item_size <= item_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: compare each beat with the oldest placement, drive stall
	always @(posedge clk) begin : watch
		placement_t want;
		placement_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.rejected = item_rejected;
				got.bin      = bin_chosen;
				got.covered  = bin_covered;
				got.total    = covered_total;
				if (placement_q.size() == 0) begin
					log_fault($sformatf("unexpected beat rej=%0b bin=%0d cov=%0b total=%0d",
						got.rejected, got.bin, got.covered, got.total));
				end else begin
					want = placement_q.pop_front();
					if (got.rejected !== want.rejected || got.bin !== want.bin ||
							got.covered !== want.covered || got.total !== want.total)
						log_fault($sformatf({"mismatch exp rej=%0b bin=%0d cov=%0b total=%0d",
							" got rej=%0b bin=%0d cov=%0b total=%0d"},
							want.rejected, want.bin, want.covered, want.total,
							got.rejected, got.bin, got.covered, got.total));
				end
			end
			out_stall <= (hold_cnt != 0) || ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Long receiver hold-off, started by toggling hold_req
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_cnt <= HOLD_CYCLES;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		logic [ITEM_W-1:0] thr;
		logic [ITEM_W-1:0] cls;
		int                idle_sel;
		foreach (bin_fill[i])
			bin_fill[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset settings, next fit into bin 0
		item_q.push_back('0);
		item_q.push_back(ITEM_W'(1));
		item_q.push_back(ITEM_W'(999));
		item_q.push_back(ITEM_W'(1));
		item_q.push_back(ITEM_W'(1000));
		item_q.push_back(ITEM_W'(1001));
		item_q.push_back(ITEM_MAX);
		item_q.push_back(ITEM_W'(500));
		item_q.push_back(ITEM_W'(500));
		drain();

		// Harmonic with four classes: each class plus the fall-through bin
		write_reg(REG_MODE, ITEM_W'(MODE_HARMONIC));
		write_reg(REG_CLASSES, ITEM_W'(4));
		item_q.push_back(ITEM_W'(500));
		item_q.push_back(ITEM_W'(334));
		item_q.push_back(ITEM_W'(333));
		item_q.push_back(ITEM_W'(100));
		item_q.push_back(ITEM_W'(250));
		item_q.push_back(ITEM_W'(1000));
		drain();

		// Class count below two and above the maximum; bins keep their levels
		write_reg(REG_CLASSES, '0);
		item_q.push_back(ITEM_W'(100));
		drain();
		write_reg(REG_CLASSES, ITEM_W'(127));
		item_q.push_back(ITEM_W'(1));
		item_q.push_back(ITEM_W'(16));
		drain();

		// Threshold extremes, including zero where nothing fits
		write_reg(REG_THRESHOLD, ITEM_MAX);
		item_q.push_back(ITEM_MAX);
		item_q.push_back(ITEM_W'(1));
		drain();
		write_reg(REG_THRESHOLD, ITEM_W'(1));
		item_q.push_back(ITEM_W'(1));
		item_q.push_back(ITEM_W'(2));
		drain();
		write_reg(REG_THRESHOLD, '0);
		item_q.push_back(ITEM_W'(1));
		item_q.push_back('0);
		drain();
		write_reg(REG_UNUSED, ITEM_MAX);
		item_q.push_back(ITEM_W'(1));
		drain();

		// Random phases, each with its own settings and idling pattern
		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0:       thr = ITEM_W'($urandom_range(1, 64));
				1:       thr = ITEM_W'($urandom_range(900, 1100));
				2:       thr = ITEM_W'($urandom_range(1, ITEM_MAX));
				default: thr = (p == 3) ? ITEM_W'(1) : (p == 7) ? ITEM_MAX :
					ITEM_W'($urandom_range(1, 1_000_000_000));
			endcase
			case (p)
				5:       cls = '0;
				9:       cls = ITEM_W'(1);
				11:      cls = ITEM_W'(CLASSES_MAX);
				13:      cls = ITEM_W'(127);
				15:      cls = ITEM_W'($urandom_range(0, 127));
				default: cls = ITEM_W'($urandom_range(2, 8));
			endcase
			write_reg(REG_MODE, (p % 3 == 0) ? ITEM_W'(MODE_NEXT_FIT) : ITEM_W'(MODE_HARMONIC));
			write_reg(REG_THRESHOLD, thr);
			write_reg(REG_CLASSES, cls);

			idle_sel = (p + p / 4) % 4;
			case (idle_sel)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 47;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 47;
				end
				default: begin
					send_idle_pct = 22;
					stall_pct     = 22;
				end
			endcase

			if (p == 6) begin
				// sender pauses halfway until every placement is out
				repeat (PHASE_ITEMS / 2) item_q.push_back(pick_size());
				drain();
				repeat (PHASE_ITEMS / 2) item_q.push_back(pick_size());
			end else begin
				repeat (PHASE_ITEMS) item_q.push_back(pick_size());
			end
			if (p == 0) begin
				// receiver holds off while the sender keeps offering
				@(posedge clk);
				hold_req <= ~hold_req;
			end
			drain();
		end

		// Zero threshold: every size is turned away
		write_reg(REG_THRESHOLD, '0);
		send_idle_pct = 22;
		stall_pct     = 22;
		repeat (20) item_q.push_back(pick_size());
		drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (placement_q.size() != 0)
			log_fault($sformatf("%0d placements never came out", placement_q.size()));
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/obc_pkg.sv
rtl/online_bin_covering.sv
rtl/obc_check.sv
verif/tb_online_bin_covering.sv
